[rtl/core/ptt_pkg.sv]
// ptt_pkg: shared types and constants for the pulse train trigger.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package ptt_pkg;

  localparam int DurW   = 16;
  localparam int CountW = 8;
  localparam int GapW   = 16;
  localparam int CmdW   = 2;

  // command codes
  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_START = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 2'd2;

  localparam logic [DurW-1:0]   DEFAULT_LEN   = 16'd500;
  localparam logic [GapW-1:0]   DEFAULT_GAP   = 16'd150;
  localparam logic [CountW-1:0] DEFAULT_COUNT = 8'd1;
  localparam logic [DurW-1:0]   ELAPSED_MAX   = '1;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [DurW-1:0]   dur_ticks;
    logic [CountW-1:0] num_pulses;
    logic              polarity;
    logic              relay_on;
  } item_t;

  typedef struct packed {
    logic trigger_level;
    logic relay_level;
    logic busy_res;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/ptt_in_stage.sv]
// ptt_in_stage: input register for the command channel.
// Holds one item until the core consumes it; uses ptt_pkg.
`default_nettype none

module ptt_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ptt_pkg::item_t in_item,
  output logic                s_valid,
  output ptt_pkg::item_t      s_item,
  input  wire logic           s_take
);

  logic           valid_r;
  ptt_pkg::item_t item_r;

  // free now, or emptied by the core in this same cycle
  assign in_ready = !valid_r || s_take;
  assign s_valid  = valid_r;
  assign s_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (s_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ptt_core.sv]
// ptt_core: pulse train state machine, gap register and line levels.
// Consumes one item per fire and returns the levels after it; uses ptt_pkg.
`default_nettype none

module ptt_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ptt_pkg::GapW-1:0]    cfg_wdata,
  input  wire logic                        fire,
  input  wire ptt_pkg::item_t              item,
  output ptt_pkg::res_t                    res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [ptt_pkg::GapW-1:0]      gap_r;
  logic [ptt_pkg::DurW-1:0]      elapsed_r, elapsed_nxt, elapsed_inc;
  logic [ptt_pkg::CountW-1:0]    done_r, done_nxt, done_inc;
  logic [ptt_pkg::DurW-1:0]      length_r, length_nxt;
  logic [ptt_pkg::CountW-1:0]    target_r, target_nxt;
  logic                          high_r, high_nxt;
  logic                          relay_en_r, relay_en_nxt;
  logic                          trig_r, trig_nxt;
  logic                          relay_r, relay_nxt;

  // saturating tick count
  assign elapsed_inc = (elapsed_r == ptt_pkg::ELAPSED_MAX) ? elapsed_r
                                                           : elapsed_r + 1'b1;
  assign done_inc    = done_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    done_nxt     = done_r;
    length_nxt   = length_r;
    target_nxt   = target_r;
    high_nxt     = high_r;
    relay_en_nxt = relay_en_r;
    trig_nxt     = trig_r;
    relay_nxt    = relay_r;
    case (item.cmd)
      ptt_pkg::CMD_START: begin
        length_nxt   = (item.dur_ticks != '0) ? item.dur_ticks : ptt_pkg::DEFAULT_LEN;
        target_nxt   = (item.num_pulses != '0) ? item.num_pulses : ptt_pkg::DEFAULT_COUNT;
        done_nxt     = '0;
        high_nxt     = item.polarity;
        relay_en_nxt = item.relay_on;
        elapsed_nxt  = '0;
        phase_nxt    = PH_PULSE;
        trig_nxt     = item.polarity;
        if (item.relay_on) begin
          relay_nxt = 1'b1;
        end
      end
      ptt_pkg::CMD_STOP: begin
        trig_nxt  = 1'b1;
        relay_nxt = 1'b0;
        phase_nxt = PH_IDLE;
      end
      ptt_pkg::CMD_TICK: begin
        case (phase_r)
          PH_PULSE: begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= length_r) begin
              trig_nxt = !high_r;
              if (relay_en_r) begin
                relay_nxt = 1'b0;
              end
              done_nxt = done_inc;
              if (done_inc < target_r) begin
                phase_nxt   = PH_GAP;
                elapsed_nxt = '0;
              end else begin
                // last pulse: release regardless of polarity
                trig_nxt  = 1'b1;
                relay_nxt = 1'b0;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_GAP: begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= gap_r) begin
              phase_nxt   = PH_PULSE;
              elapsed_nxt = '0;
              trig_nxt    = high_r;
              if (relay_en_r) begin
                relay_nxt = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign res.trigger_level = trig_nxt;
  assign res.relay_level   = relay_nxt;
  assign res.busy_res      = (phase_nxt != PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      gap_r      <= ptt_pkg::DEFAULT_GAP;
      elapsed_r  <= '0;
      done_r     <= '0;
      length_r   <= ptt_pkg::DEFAULT_LEN;
      target_r   <= ptt_pkg::DEFAULT_COUNT;
      high_r     <= 1'b0;
      relay_en_r <= 1'b0;
      trig_r     <= 1'b1;
      relay_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        elapsed_r  <= elapsed_nxt;
        done_r     <= done_nxt;
        length_r   <= length_nxt;
        target_r   <= target_nxt;
        high_r     <= high_nxt;
        relay_en_r <= relay_en_nxt;
        trig_r     <= trig_nxt;
        relay_r    <= relay_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ptt_out_stage.sv]
// ptt_out_stage: result register for the level channel.
// Tells the core when it may fire; uses ptt_pkg.
`default_nettype none

module ptt_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          s_valid,
  output logic               s_take,
  input  wire ptt_pkg::res_t s_res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ptt_pkg::res_t      out_res
);

  logic          valid_r;
  ptt_pkg::res_t res_r;

  // load when empty or when the held result leaves this cycle
  assign s_take    = s_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      res_r <= s_res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pulse_train_trigger.sv]
// pulse_train_trigger: top level of the pulse train generator.
// Instantiates ptt_in_stage, ptt_core and ptt_out_stage; uses ptt_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       cmd, duration, count, polarity, relay
//   out      output     out_valid / out_ready     trigger, relay, busy levels
//   cfg      input      cfg_we (no wait)          gap length in ticks
//
// One item per cycle sustained while the out side accepts; out_valid rises once the in transfer
// has passed the input register and then the state update into the result register.
// The state machine advances only when the result register can take the levels.
// A stalled out side holds one result and one further item in the input register.
// Synchronous active-low reset: lines released, gap 150, no clearing pass.
`default_nettype none

module pulse_train_trigger (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ptt_pkg::CmdW-1:0]       in_cmd,
  input  wire logic [ptt_pkg::DurW-1:0]       in_dur_ticks,
  input  wire logic [ptt_pkg::CountW-1:0]     in_num_pulses,
  input  wire logic                           in_polarity,
  input  wire logic                           in_relay_on,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_trigger_level,
  output logic                                out_relay_level,
  output logic                                out_busy_res,
  input  wire logic                           cfg_we,
  input  wire logic [ptt_pkg::GapW-1:0]       cfg_wdata
);

  ptt_pkg::item_t in_item, s_item;
  ptt_pkg::res_t  s_res, out_res;
  logic           s_valid, s_take;

  assign in_item.cmd        = in_cmd;
  assign in_item.dur_ticks  = in_dur_ticks;
  assign in_item.num_pulses = in_num_pulses;
  assign in_item.polarity   = in_polarity;
  assign in_item.relay_on   = in_relay_on;

  ptt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (s_take)
  );

  ptt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (s_take),
    .item      (s_item),
    .res       (s_res)
  );

  ptt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_take    (s_take),
    .s_res     (s_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_trigger_level = out_res.trigger_level;
  assign out_relay_level   = out_res.relay_level;
  assign out_busy_res      = out_res.busy_res;

endmodule

`default_nettype wire

[dv/pulse_train_trigger_tb.sv]
// pulse_train_trigger_tb: self-checking testbench for the pulse train trigger.
// Drives start/tick/stop transfers and gap register writes, predicts the line levels.
// Depends on ptt_pkg and the pulse_train_trigger RTL.
`default_nettype none

module pulse_train_trigger_tb;

  localparam logic [ptt_pkg::CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {TRAIN_IDLE, TRAIN_PULSE, TRAIN_GAP} train_phase_t;

  // Predicts the trigger, relay and busy levels and holds them until they come out.
  class train_scoreboard;
    logic [ptt_pkg::GapW-1:0]   gap_len;
    train_phase_t               phase;
    logic [ptt_pkg::DurW-1:0]   elapsed;
    logic [ptt_pkg::CountW-1:0] pulses_done;
    logic [ptt_pkg::DurW-1:0]   pulse_len;
    logic [ptt_pkg::CountW-1:0] pulse_goal;
    logic                       act_high;
    logic                       relay_en;
    logic                       trig_lvl;
    logic                       relay_lvl;
    ptt_pkg::res_t              levels_q[$];
    int                         errors;

    function new();
      gap_len     = ptt_pkg::DEFAULT_GAP;
      phase       = TRAIN_IDLE;
      elapsed     = '0;
      pulses_done = '0;
      pulse_len   = ptt_pkg::DEFAULT_LEN;
      pulse_goal  = ptt_pkg::DEFAULT_COUNT;
      act_high    = 1'b0;
      relay_en    = 1'b0;
      trig_lvl    = 1'b1;
      relay_lvl   = 1'b0;
      errors      = 0;
    endfunction

    function void set_gap(logic [ptt_pkg::GapW-1:0] g);
      gap_len = g;
    endfunction

    function int pending();
      return levels_q.size();
    endfunction

    function void bump_elapsed();
      if (elapsed != ptt_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
    endfunction

    // released lines are high/low regardless of polarity
    function void release_lines();
      trig_lvl  = 1'b1;
      relay_lvl = 1'b0;
      phase     = TRAIN_IDLE;
    endfunction

    function void note_input(ptt_pkg::item_t it);
      ptt_pkg::res_t r;
      case (it.cmd)
        ptt_pkg::CMD_START: begin
          pulse_len   = (it.dur_ticks != 0) ? it.dur_ticks : ptt_pkg::DEFAULT_LEN;
          pulse_goal  = (it.num_pulses != 0) ? it.num_pulses : ptt_pkg::DEFAULT_COUNT;
          pulses_done = '0;
          act_high    = it.polarity;
          relay_en    = it.relay_on;
          elapsed     = '0;
          phase       = TRAIN_PULSE;
          trig_lvl    = act_high;
          if (relay_en) relay_lvl = 1'b1;
        end
        ptt_pkg::CMD_STOP: release_lines();
        ptt_pkg::CMD_TICK: begin
          if (phase == TRAIN_PULSE) begin
            bump_elapsed();
            if (elapsed >= pulse_len) begin
              trig_lvl = ~act_high;
              if (relay_en) relay_lvl = 1'b0;
              pulses_done = pulses_done + 1'b1;
              if (pulses_done < pulse_goal) begin
                phase   = TRAIN_GAP;
                elapsed = '0;
              end else begin
                release_lines();
              end
            end
          end else if (phase == TRAIN_GAP) begin
            bump_elapsed();
            // compared after the increment: a zero gap ends on the first tick
            if (elapsed >= gap_len) begin
              phase    = TRAIN_PULSE;
              elapsed  = '0;
              trig_lvl = act_high;
              if (relay_en) relay_lvl = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.trigger_level = trig_lvl;
      r.relay_level   = relay_lvl;
      r.busy_res      = (phase != TRAIN_IDLE);
      levels_q.push_back(r);
    endfunction

    function void compare_level(string name, logic exp_v, logic got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(ptt_pkg::res_t got);
      ptt_pkg::res_t exp_r;
      if (levels_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %b", $time, got);
        errors++;
        return;
      end
      exp_r = levels_q.pop_front();
      compare_level("trigger_level", exp_r.trigger_level, got.trigger_level);
      compare_level("relay_level", exp_r.relay_level, got.relay_level);
      compare_level("busy_res", exp_r.busy_res, got.busy_res);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  ptt_pkg::item_t           in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic                     out_trigger_level;
  logic                     out_relay_level;
  logic                     out_busy_res;
  logic                     cfg_we = 1'b0;
  logic [ptt_pkg::GapW-1:0] cfg_wdata = '0;

  train_scoreboard sb;
  int burst_left = 0;
  bit hold_req = 1'b0;
  int rx_cycle;
  int hold_left;

  always #5 clk = ~clk;

  pulse_train_trigger uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_item.cmd),
    .in_dur_ticks      (in_item.dur_ticks),
    .in_num_pulses     (in_item.num_pulses),
    .in_polarity       (in_item.polarity),
    .in_relay_on       (in_item.relay_on),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_relay_level   (out_relay_level),
    .out_busy_res      (out_busy_res),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(ptt_pkg::res_t'({out_trigger_level, out_relay_level, out_busy_res}));
  end

  // receiver: rotates through four stall patterns, plus one long hold-off on request
  initial begin
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ((rx_cycle % 4) != 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic ptt_pkg::item_t mk_item(logic [ptt_pkg::CmdW-1:0] cmd, int dur,
                                             int cnt, bit pol, bit rel);
    ptt_pkg::item_t it;
    it.cmd        = cmd;
    it.dur_ticks  = dur[ptt_pkg::DurW-1:0];
    it.num_pulses = cnt[ptt_pkg::CountW-1:0];
    it.polarity   = pol;
    it.relay_on   = rel;
    return it;
  endfunction

  // payload of a tick is ignored, so it carries random bits
  function automatic ptt_pkg::item_t rand_item(logic [ptt_pkg::CmdW-1:0] cmd);
    return mk_item(cmd, $urandom_range(0, 65535), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send(ptt_pkg::item_t it);
    int idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic write_gap(logic [ptt_pkg::GapW-1:0] g);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_gap(g);
  endtask

  // runs with the reset gap of 150
  task automatic run_directed();
    send(rand_item(ptt_pkg::CMD_TICK));                      // tick while idle
    send(rand_item(ptt_pkg::CMD_STOP));                      // stop while idle
    send(rand_item(CMD_UNUSED));
    send(mk_item(ptt_pkg::CMD_START, 2, 1, 1'b1, 1'b1));
    send(rand_item(ptt_pkg::CMD_TICK));
    send(rand_item(ptt_pkg::CMD_TICK));                      // single pulse ends
    send(mk_item(ptt_pkg::CMD_START, 1, 0, 1'b0, 1'b1));     // relay goes high
    send(mk_item(ptt_pkg::CMD_START, 3, 3, 1'b1, 1'b0));     // restart, relay kept
    repeat (3) send(rand_item(ptt_pkg::CMD_TICK));
    send(rand_item(ptt_pkg::CMD_TICK));                      // inside the gap
    send(rand_item(CMD_UNUSED));
    send(rand_item(ptt_pkg::CMD_STOP));                      // stop mid train
    send(mk_item(ptt_pkg::CMD_START, 0, 255, 1'b0, 1'b0));   // default length
    send(rand_item(ptt_pkg::CMD_TICK));
    send(mk_item(ptt_pkg::CMD_START, 65535, 0, 1'b1, 1'b1));
    send(rand_item(ptt_pkg::CMD_TICK));
    send(rand_item(ptt_pkg::CMD_STOP));
    send(mk_item(ptt_pkg::CMD_START, 16'hAAAA, 8'h55, 1'b0, 1'b1));
    send(mk_item(ptt_pkg::CMD_START, 16'h5555, 8'hAA, 1'b1, 1'b0));
    send(rand_item(ptt_pkg::CMD_STOP));
  endtask

  // trains with random content, many cut short by the tick count, some stopped early, some noise
  task automatic run_trains(int budget, int max_dur, int max_cnt);
    int sent;
    int dur;
    int cnt;
    int span;
    int n_ticks;
    int stop_at;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 19))
          0: dur = 0;
          1, 2: dur = $urandom_range(0, 65535);
          default: dur = $urandom_range(1, max_dur);
        endcase
        case ($urandom_range(0, 19))
          0: cnt = 0;
          1: cnt = $urandom_range(0, 255);
          default: cnt = $urandom_range(1, max_cnt);
        endcase
        send(mk_item(ptt_pkg::CMD_START, dur, cnt,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
        if (dur == 0) dur = int'(ptt_pkg::DEFAULT_LEN);
        if (cnt == 0) cnt = int'(ptt_pkg::DEFAULT_COUNT);
        span = dur * cnt + int'(sb.gap_len) * (cnt - 1) + 2;
        if (span > 180) span = $urandom_range(5, 40);
        n_ticks = $urandom_range(span / 2, span + 2);
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ticks) : -1;
        for (int k = 0; k < n_ticks; k++) begin
          if (k == stop_at)
            send(rand_item(ptt_pkg::CMD_STOP));
          else if ($urandom_range(0, 29) == 0)
            send(rand_item(CMD_UNUSED));
          else
            send(rand_item(ptt_pkg::CMD_TICK));
        end
        sent += n_ticks;
      end else begin
        send(rand_item(2'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  initial begin
    #500000;
    $display("** pulse_train_trigger: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_trains(110, 3, 2);
    write_gap(16'd0);
    hold_req = 1'b1;
    run_trains(70, 4, 4);
    write_gap(16'd1);
    run_trains(60, 4, 4);
    write_gap(16'hFFFF);
    run_trains(40, 4, 3);
    write_gap(16'($urandom_range(2, 9)));
    run_trains(90, 5, 4);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("** pulse_train_trigger: PASSED **");
    else
      $display("** pulse_train_trigger: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/ptt_pkg.sv
rtl/core/ptt_in_stage.sv
rtl/core/ptt_core.sv
rtl/core/ptt_out_stage.sv
rtl/core/pulse_train_trigger.sv
dv/pulse_train_trigger_tb.sv
